// ===== rtl/core/dpq_pkg.sv =====
`timescale 1ns / 1ps

package dpq_pkg;

	localparam int CAPACITY = 64;
	localparam int PRI_BITS = 24;
	localparam int CLI_BITS = 20;

	localparam logic [1:0] OP_INSERT  = 2'd0;
	localparam logic [1:0] OP_POP_MAX = 2'd1;
	localparam logic [1:0] OP_POP_MIN = 2'd2;

	localparam logic [1:0] ST_SERVED  = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_DROPPED = 2'd2;

	// Priority sits in the upper bits, so a plain compare of the packed
	// value orders by priority first and by client id second.
	typedef struct packed {
		logic [PRI_BITS-1:0] pri;
		logic [CLI_BITS-1:0] cli;
	} key_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;
		logic pop_min;
		logic pop_max;
		key_t key;
	} cell_ctrl_t;

endpackage

// ===== rtl/core/dpq_cell.sv =====
`timescale 1ns / 1ps

module dpq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  dpq_pkg::cell_ctrl_t ctrl,
	input  dpq_pkg::key_t      left_key,
	input  logic               left_lt,
	input  logic               left_valid,
	input  dpq_pkg::key_t      right_key,
	input  logic               right_valid,
	output dpq_pkg::key_t      key,
	output logic               valid,
	output logic               lt,
	output logic               eq
);

	dpq_pkg::key_t key_q;
	logic          valid_q;

	assign key   = key_q;
	assign valid = valid_q;
	// The row is sorted, so the cells below the new key form a prefix.
	assign lt    = valid_q && (key_q < ctrl.key);
	assign eq    = valid_q && (key_q == ctrl.key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.ins) begin
			valid_q <= valid_q | left_valid;
		end else if (ctrl.pop_min) begin
			valid_q <= right_valid;
		end else if (ctrl.pop_max) begin
			valid_q <= valid_q & right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (!lt) begin
				key_q <= left_lt ? ctrl.key : left_key;
			end
		end else if (ctrl.pop_min) begin
			key_q <= right_key;
		end
	end

endmodule

// ===== rtl/core/double_ended_priority_queue_top.sv =====
`timescale 1ns / 1ps
// Each pop, and each insert dropped on a full row, gives a result strobe (done) from the
// result register, which is loaded from the command register; busy is high for the cycle in which
// the cell row compares and shifts, no new command is taken then, and the receiver cannot stall results.
// Reset (arst_n low, asynchronous) empties the queue and clears busy and done;
// stored entries are not cleared, they are only marked unoccupied.

module double_ended_priority_queue_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   operation,
	input  logic [dpq_pkg::CLI_BITS-1:0] client_id,
	input  logic [dpq_pkg::PRI_BITS-1:0] priority_req,
	output logic                         done,
	output logic [dpq_pkg::CLI_BITS-1:0] served_client,
	output logic [1:0]                   status
);

	// Command register. A transfer loads it, and it is applied to the cell
	// row in the following cycle, during which busy holds off new commands.
	logic          cmd_valid_s1;
	logic [1:0]    op_s1;
	dpq_pkg::key_t key_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else begin
			cmd_valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1      <= operation;
			key_s1.pri <= priority_req;
			key_s1.cli <= client_id;
		end
	end

	assign busy = cmd_valid_s1;

	// The row of cells holds the entries in ascending order, cell 0 being
	// the smallest. Occupied cells always form a prefix of the row.
	dpq_pkg::key_t                 key_w [dpq_pkg::CAPACITY];
	logic [dpq_pkg::CAPACITY-1:0]  valid_w;
	logic [dpq_pkg::CAPACITY-1:0]  lt_w;
	logic [dpq_pkg::CAPACITY-1:0]  eq_w;
	dpq_pkg::cell_ctrl_t           ctrl;

	logic dup, full, empty;
	logic is_ins, is_max, is_min;

	assign dup    = |eq_w;
	assign full   = valid_w[dpq_pkg::CAPACITY-1];
	assign empty  = !valid_w[0];
	assign is_ins = cmd_valid_s1 && (op_s1 == dpq_pkg::OP_INSERT);
	assign is_max = cmd_valid_s1 && (op_s1 == dpq_pkg::OP_POP_MAX);
	assign is_min = cmd_valid_s1 && (op_s1 == dpq_pkg::OP_POP_MIN);

	// An identical pair already stored makes the insert a no-op, even when
	// the row is full. Pops on an empty row leave the row alone.
	assign ctrl.ins     = is_ins && !dup && !full;
	assign ctrl.pop_min = is_min && !empty;
	assign ctrl.pop_max = is_max && !empty;
	assign ctrl.key     = key_s1;

	genvar gi;
	generate
		for (gi = 0; gi < dpq_pkg::CAPACITY; gi++) begin : g_cell
			dpq_pkg::key_t lkey, rkey;
			logic          llt, lvalid, rvalid;

			if (gi == 0) begin : g_first
				// The head cell sees an always-smaller, always-occupied neighbor,
				// so a new smallest key lands in it.
				assign lkey   = key_s1;
				assign llt    = 1'b1;
				assign lvalid = 1'b1;
			end else begin : g_mid_l
				assign lkey   = key_w[gi-1];
				assign llt    = lt_w[gi-1];
				assign lvalid = valid_w[gi-1];
			end

			if (gi == dpq_pkg::CAPACITY - 1) begin : g_last
				assign rkey   = key_w[gi];
				assign rvalid = 1'b0;
			end else begin : g_mid_r
				assign rkey   = key_w[gi+1];
				assign rvalid = valid_w[gi+1];
			end

			dpq_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.left_key   (lkey),
				.left_lt    (llt),
				.left_valid (lvalid),
				.right_key  (rkey),
				.right_valid(rvalid),
				.key        (key_w[gi]),
				.valid      (valid_w[gi]),
				.lt         (lt_w[gi]),
				.eq         (eq_w[gi])
			);
		end
	endgenerate

	// The largest entry sits in the last occupied cell, the one whose right
	// neighbor is empty. Exactly one cell matches when the row is not empty,
	// so an OR over the masked clients selects it.
	logic [dpq_pkg::CAPACITY-1:0]  last_w;
	logic [dpq_pkg::CLI_BITS-1:0]  max_cli;

	assign last_w = valid_w & ~{1'b0, valid_w[dpq_pkg::CAPACITY-1:1]};

	always_comb begin
		max_cli = '0;
		for (int i = 0; i < dpq_pkg::CAPACITY; i++) begin
			if (last_w[i]) begin
				max_cli = max_cli | key_w[i].cli;
			end
		end
	end

	// Result register. A result is produced by every pop and by an insert
	// that is dropped because the row is full.
	logic                         done_q;
	logic [dpq_pkg::CLI_BITS-1:0] served_client_q;
	logic [1:0]                   status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (is_ins && !dup && full) || is_max || is_min;
		end
	end

	always_ff @(posedge clk) begin
		if (is_ins) begin
			served_client_q <= '0;
			status_q        <= dpq_pkg::ST_DROPPED;
		end else if (empty) begin
			served_client_q <= '0;
			status_q        <= dpq_pkg::ST_EMPTY;
		end else begin
			served_client_q <= is_min ? key_w[0].cli : max_cli;
			status_q        <= dpq_pkg::ST_SERVED;
		end
	end

	assign done          = done_q;
	assign served_client = served_client_q;
	assign status        = status_q;

endmodule

// ===== rtl/core/dpq_checker.sv =====
`timescale 1ns / 1ps

module dpq_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [dpq_pkg::CLI_BITS-1:0] served_client,
	input logic [1:0]                   status
);

	// A command transfer is followed by exactly one busy cycle.
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after a command transfer");

	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");

	// A result only ever follows the processing cycle of a command.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a command in process");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == dpq_pkg::ST_SERVED || status == dpq_pkg::ST_EMPTY ||
			status == dpq_pkg::ST_DROPPED))
		else $error("result carries an undefined status");

	a_zero_client: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != dpq_pkg::ST_SERVED) |-> (served_client == '0))
		else $error("client not zero on an empty or dropped result");

endmodule

bind double_ended_priority_queue_top dpq_checker u_dpq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.served_client(served_client),
	.status       (status)
);
